// ===== sv/morse_code_encoder_assert.svh =====
// Assertion macros for the Morse encoder RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef MORSE_CODE_ENCODER_ASSERT_SVH
`define MORSE_CODE_ENCODER_ASSERT_SVH

// Check that a property holds at every clock edge outside reset.
`define MCE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define MCE_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== sv/mce_pkg.sv =====
// Package for the Morse encoder: types, register indexes and fixed codes.
// Used by mce_lookup, mce_emitter and morse_code_encoder; no dependencies.
`timescale 1ns / 1ps

package mce_pkg;

    localparam int CODE_W = 6;   // longest code in the table
    localparam int LEN_W  = 3;
    localparam int DUR_W  = 13;
    localparam int FREQ_W = 15;
    localparam int DIT_W  = 10;
    localparam int GLY_W  = 7;

    localparam logic [1:0] CFG_OUTPUT_MODE    = 2'd0;
    localparam logic [1:0] CFG_TONE_FREQUENCY = 2'd1;
    localparam logic [1:0] CFG_DIT_DURATION   = 2'd2;

    localparam logic [FREQ_W-1:0] FREQ_RESET = 15'd800;
    localparam logic [DIT_W-1:0]  DIT_RESET  = 10'd100;

    localparam logic [7:0]       CHAR_SPACE  = 8'h20;
    localparam logic [GLY_W-1:0] GLYPH_DOT   = 7'h2E;
    localparam logic [GLY_W-1:0] GLYPH_DASH  = 7'h2D;
    localparam logic [GLY_W-1:0] GLYPH_SPACE = 7'h20;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ELEM,
        ST_GAP,
        ST_CEND,
        ST_WSPACE
    } t_state;

    // Decoded character: pattern bit 0 is the first element, 1 means dash.
    typedef struct packed {
        logic              ok;
        logic              space;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] pat;
    } t_code;

    typedef struct packed {
        logic [GLY_W-1:0]  glyph;
        logic              tone_on;
        logic [FREQ_W-1:0] pitch;
        logic [DUR_W-1:0]  dur;
        logic              last;
    } t_seg;

endpackage

// ===== sv/morse_code_encoder.sv =====
// Accepted characters pass the sequencer state, then the output register, to m_axis.
// Throughput: one segment per cycle while m_axis_tready is high; the sequencer takes a
// new character only when idle, after the last segment of the previous one is loaded.
// Unknown characters are dropped; a word space is one segment (tone) or three (text).
// Reset (i_rst_n low, synchronous): sequencer idle, output empty, output_mode 0,
// tone_frequency 800, dit_duration 100.
`timescale 1ns / 1ps

module morse_code_encoder
    import mce_pkg::*;
#(
    parameter int MAX_ELEMENTS = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data,
    // character input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    // segment output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [6:0] glyph, [7] tone_on, [22:8] pitch,
                                        // [35:23] duration_ms, [39:36] zero
    output logic        m_axis_tlast    // last segment of the character
);

    logic              r_mode;
    logic [FREQ_W-1:0] r_freq;
    logic [DIT_W-1:0]  r_dit;
    t_code             code;
    t_seg              seg;

    // Registers take a beat every cycle; the user sends writes only while idle (unchecked).
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_freq <= FREQ_RESET;
            r_dit  <= DIT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OUTPUT_MODE:    r_mode <= i_cfg_data[0];
                CFG_TONE_FREQUENCY: r_freq <= i_cfg_data;
                CFG_DIT_DURATION:   r_dit  <= i_cfg_data[DIT_W-1:0];
                default: ;          // drop writes to unused indexes
            endcase
        end
    end

    // Decode the incoming character straight off the bus; the sequencer
    // captures the pattern on the accepting edge.
    mce_lookup u_lookup (
        .i_char (s_axis_tdata),
        .o_code (code)
    );

    // Walk the pattern element by element and hold each segment in the
    // output register until the sink takes it.
    mce_emitter #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_emitter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_code  (code),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_mode  (r_mode),
        .i_freq  (r_freq),
        .i_dit   (r_dit),
        .o_seg   (seg),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready)
    );

    // Pack the segment fields, lowest field first.
    assign m_axis_tdata = {4'b0000, seg.dur, seg.pitch, seg.tone_on, seg.glyph};
    assign m_axis_tlast = seg.last;

endmodule

// ===== sv/mce_lookup.sv =====
// Character to Morse element pattern decoder.
// Depends on mce_pkg for the decoded-code struct.
`timescale 1ns / 1ps

module mce_lookup
    import mce_pkg::*;
(
    input  logic [7:0] i_char,
    output t_code      o_code
);

    logic [7:0] fold;

    function automatic t_code mk(input logic [LEN_W-1:0] n, input logic [CODE_W-1:0] p);
        t_code c;
        c.ok    = 1'b1;
        c.space = 1'b0;
        c.len   = n;
        c.pat   = p;
        return c;
    endfunction

    // Fold lower case onto upper case.
    assign fold = (i_char >= "a" && i_char <= "z") ? (i_char - 8'h20) : i_char;

    always_comb begin
        o_code = '0;
        unique case (fold)
            "A": o_code = mk(3'd2, 6'b000010);
            "B": o_code = mk(3'd4, 6'b000001);
            "C": o_code = mk(3'd4, 6'b000101);
            "D": o_code = mk(3'd3, 6'b000001);
            "E": o_code = mk(3'd1, 6'b000000);
            "F": o_code = mk(3'd4, 6'b000100);
            "G": o_code = mk(3'd3, 6'b000011);
            "H": o_code = mk(3'd4, 6'b000000);
            "I": o_code = mk(3'd2, 6'b000000);
            "J": o_code = mk(3'd4, 6'b001110);
            "K": o_code = mk(3'd3, 6'b000101);
            "L": o_code = mk(3'd4, 6'b000010);
            "M": o_code = mk(3'd2, 6'b000011);
            "N": o_code = mk(3'd2, 6'b000001);
            "O": o_code = mk(3'd3, 6'b000111);
            "P": o_code = mk(3'd4, 6'b000110);
            "Q": o_code = mk(3'd4, 6'b001011);
            "R": o_code = mk(3'd3, 6'b000010);
            "S": o_code = mk(3'd3, 6'b000000);
            "T": o_code = mk(3'd1, 6'b000001);
            "U": o_code = mk(3'd3, 6'b000100);
            "V": o_code = mk(3'd4, 6'b001000);
            "W": o_code = mk(3'd3, 6'b000110);
            "X": o_code = mk(3'd4, 6'b001001);
            "Y": o_code = mk(3'd4, 6'b001101);
            "Z": o_code = mk(3'd4, 6'b000011);
            "0": o_code = mk(3'd5, 6'b011111);
            "1": o_code = mk(3'd5, 6'b011110);
            "2": o_code = mk(3'd5, 6'b011100);
            "3": o_code = mk(3'd5, 6'b011000);
            "4": o_code = mk(3'd5, 6'b010000);
            "5": o_code = mk(3'd5, 6'b000000);
            "6": o_code = mk(3'd5, 6'b000001);
            "7": o_code = mk(3'd5, 6'b000011);
            "8": o_code = mk(3'd5, 6'b000111);
            "9": o_code = mk(3'd5, 6'b001111);
            "&": o_code = mk(3'd5, 6'b000010);
            "'": o_code = mk(3'd6, 6'b011110);
            "@": o_code = mk(3'd6, 6'b010110);
            "(": o_code = mk(3'd5, 6'b001101);
            ")": o_code = mk(3'd6, 6'b101101);
            ":": o_code = mk(3'd6, 6'b000111);
            ",": o_code = mk(3'd6, 6'b110011);
            "=": o_code = mk(3'd5, 6'b010001);
            "!": o_code = mk(3'd6, 6'b110101);
            ".": o_code = mk(3'd6, 6'b101010);
            "-": o_code = mk(3'd6, 6'b100001);
            "?": o_code = mk(3'd6, 6'b001100);
            CHAR_SPACE: o_code.space = 1'b1;
            default: o_code = '0;
        endcase
    end

endmodule

// ===== sv/mce_emitter.sv =====
// Element sequencer: shifts the pattern out element by element into an output register,
// taking a new character only when idle. Depends on mce_pkg and morse_code_encoder_assert.svh.
`timescale 1ns / 1ps
`include "morse_code_encoder_assert.svh"

module mce_emitter
    import mce_pkg::*;
#(
    parameter int MAX_ELEMENTS = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_code             i_code,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_mode,
    input  logic [FREQ_W-1:0] i_freq,
    input  logic [DIT_W-1:0]  i_dit,
    output t_seg              o_seg,
    output logic              o_valid,
    input  logic              i_ready
);

    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    t_state                  r_state, n_state;
    logic [MAX_ELEMENTS-1:0] r_pat, n_pat;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic                    r_out_valid;
    t_seg                    r_seg, seg;
    logic                    emit, load;
    logic [DUR_W-1:0]        dit1, dit2, dit3, dit5;

    assign dit1 = {3'b000, i_dit};
    assign dit2 = {2'b00, i_dit, 1'b0};
    assign dit3 = dit1 + dit2;
    assign dit5 = dit1 + {1'b0, i_dit, 2'b00};

    assign load    = !r_out_valid || i_ready;
    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_seg   = r_seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pat       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pat   <= n_pat;
            r_cnt   <= n_cnt;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_seg <= seg;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pat   = r_pat;
        n_cnt   = r_cnt;
        emit    = 1'b0;
        seg     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_code.space) begin
                        n_state = ST_WSPACE;
                        n_cnt   = i_mode ? CW'(2) : '0;
                    end else if (i_code.ok) begin
                        n_state = ST_ELEM;
                        n_pat   = MAX_ELEMENTS'(i_code.pat);
                        n_cnt   = CW'(i_code.len);
                    end
                end
            end
            ST_ELEM: begin
                if (r_cnt == '0) begin
                    n_state = ST_CEND;
                end else if (load) begin
                    emit = 1'b1;
                    if (i_mode) begin
                        seg.glyph = r_pat[0] ? GLYPH_DASH : GLYPH_DOT;
                        n_state   = (r_cnt == CW'(1)) ? ST_CEND : ST_ELEM;
                    end else begin
                        seg.tone_on = 1'b1;
                        seg.pitch   = i_freq;
                        seg.dur     = r_pat[0] ? dit3 : dit1;
                        n_state     = ST_GAP;
                    end
                    n_pat = r_pat >> 1;
                    n_cnt = r_cnt - CW'(1);
                end
            end
            ST_GAP: begin
                if (load) begin
                    emit    = 1'b1;
                    seg.dur = dit1;
                    n_state = (r_cnt == '0) ? ST_CEND : ST_ELEM;
                end
            end
            ST_CEND: begin
                if (load) begin
                    emit     = 1'b1;
                    seg.last = 1'b1;
                    if (i_mode) begin
                        seg.glyph = GLYPH_SPACE;
                    end else begin
                        seg.dur = dit2;
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_WSPACE: begin
                if (load) begin
                    emit     = 1'b1;
                    seg.last = (r_cnt == '0);
                    if (i_mode) begin
                        seg.glyph = GLYPH_SPACE;
                    end else begin
                        seg.dur = dit5;
                    end
                    if (r_cnt == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_cnt = r_cnt - CW'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    `MCE_ASSERT(a_elem_has_work, i_clk, i_rst_n,
        (r_state == ST_ELEM) |-> (r_cnt != '0), "element state with no elements left")
    `MCE_ASSERT_NEVER(a_gap_tone_only, i_clk, i_rst_n,
        (r_state == ST_GAP) && i_mode, "inter-element gap in text mode")
    `MCE_ASSERT(a_tone_no_glyph, i_clk, i_rst_n,
        (r_out_valid && r_seg.tone_on) |-> (r_seg.glyph == '0), "tone segment carries a glyph")
    `MCE_ASSERT(a_tone_word_single, i_clk, i_rst_n,
        ((r_state == ST_WSPACE) && !i_mode) |-> (r_cnt == '0),
        "tone word space longer than one segment")

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for morse_code_encoder: drives characters and register
// writes, predicts every output segment and checks each beat as it leaves.
// Depends on mce_pkg and the morse_code_encoder RTL only.
`timescale 1ns / 1ps

module tb_top;
    import mce_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 20;    // sequencer drains and drops stray codes well within this
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off, fills the block
    localparam int MAX_PRINTS    = 100;
    localparam logic [1:0] CFG_UNUSED = 2'd3;   // index with no register behind it

    // Predicts the segment stream and matches it against output beats.
    class morse_scoreboard;
        t_seg              segs_due[$];
        logic              text_mode;
        logic [FREQ_W-1:0] pitch_hz;
        logic [DIT_W-1:0]  dit_ms;
        int                n_errors;
        int                n_chars;
        int                n_segs;

        function new();
            text_mode = 1'b0;
            pitch_hz  = FREQ_RESET;
            dit_ms    = DIT_RESET;
            n_errors  = 0;
            n_chars   = 0;
            n_segs    = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [14:0] val);
            case (idx)
                CFG_OUTPUT_MODE:    text_mode = val[0];
                CFG_TONE_FREQUENCY: pitch_hz  = val[FREQ_W-1:0];
                CFG_DIT_DURATION:   dit_ms    = val[DIT_W-1:0];
                default: ;
            endcase
        endfunction

        // Dot/dash string for a character; empty when it has no code.
        function string morse_of(logic [7:0] c);
            logic [7:0] u;
            u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
            case (u)
                "A": return ".-";     "B": return "-...";   "C": return "-.-.";
                "D": return "-..";    "E": return ".";      "F": return "..-.";
                "G": return "--.";    "H": return "....";   "I": return "..";
                "J": return ".---";   "K": return "-.-";    "L": return ".-..";
                "M": return "--";     "N": return "-.";     "O": return "---";
                "P": return ".--.";   "Q": return "--.-";   "R": return ".-.";
                "S": return "...";    "T": return "-";      "U": return "..-";
                "V": return "...-";   "W": return ".--";    "X": return "-..-";
                "Y": return "-.--";   "Z": return "--..";
                "0": return "-----";  "1": return ".----";  "2": return "..---";
                "3": return "...--";  "4": return "....-";  "5": return ".....";
                "6": return "-....";  "7": return "--...";  "8": return "---..";
                "9": return "----.";
                "&": return ".-...";  "'": return ".----."; "@": return ".--.-.";
                "(": return "-.--.";  ")": return "-.--.-"; ":": return "---...";
                ",": return "--..--"; "=": return "-...-";  "!": return "-.-.--";
                ".": return ".-.-.-"; "-": return "-....-"; "?": return "..--..";
                default: return "";
            endcase
        endfunction

        function void push_seg(logic [GLY_W-1:0] glyph, logic tone, logic [FREQ_W-1:0] pitch,
                               int dits);
            t_seg s;
            s.glyph   = glyph;
            s.tone_on = tone;
            s.pitch   = pitch;
            s.dur     = DUR_W'(dits * int'(dit_ms));
            s.last    = 1'b0;
            segs_due.push_back(s);
        endfunction

        // Queue the segments that one accepted character causes.
        function void note_char(logic [7:0] c);
            string code;
            int    n_before;
            n_chars++;
            n_before = segs_due.size();
            code     = morse_of(c);
            if (c == CHAR_SPACE) begin
                if (text_mode)
                    repeat (3) push_seg(GLYPH_SPACE, 1'b0, '0, 0);
                else
                    push_seg('0, 1'b0, '0, 5);
            end else if (code.len() != 0) begin
                for (int i = 0; i < code.len(); i++) begin
                    if (text_mode) begin
                        push_seg(code.getc(i) == "-" ? GLYPH_DASH : GLYPH_DOT, 1'b0, '0, 0);
                    end else begin
                        push_seg('0, 1'b1, pitch_hz, code.getc(i) == "-" ? 3 : 1);
                        push_seg('0, 1'b0, '0, 1);
                    end
                end
                if (text_mode)
                    push_seg(GLYPH_SPACE, 1'b0, '0, 0);
                else
                    push_seg('0, 1'b0, '0, 2);
            end
            if (segs_due.size() > n_before)
                segs_due[segs_due.size()-1].last = 1'b1;
        endfunction

        task report(string what, int got, int want);
            n_errors++;
            if (n_errors <= MAX_PRINTS)
                $display("%0t mismatch on segment %0d: %s got %0d expected %0d",
                         $time, n_segs, what, got, want);
        endtask

        task check_seg(t_seg got, logic [3:0] pad);
            t_seg want;
            if (segs_due.size() == 0) begin
                report("unexpected segment, glyph", got.glyph, -1);
            end else begin
                want = segs_due.pop_front();
                if (got.glyph !== want.glyph)     report("glyph", got.glyph, want.glyph);
                if (got.tone_on !== want.tone_on) report("tone_on", got.tone_on, want.tone_on);
                if (got.pitch !== want.pitch)     report("pitch", got.pitch, want.pitch);
                if (got.dur !== want.dur)         report("duration_ms", got.dur, want.dur);
                if (got.last !== want.last)       report("last", got.last, want.last);
                if (pad !== 4'd0)                 report("tdata pad", pad, 0);
            end
            n_segs++;
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [14:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] char_code
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;     // [6:0] glyph, [7] tone_on, [22:8] pitch, [35:23] duration_ms
    logic        m_axis_tlast;

    morse_scoreboard sb = new();
    logic no_idle  = 1'b0;   // both sides run flat out while set
    logic hold_req = 1'b0;   // ask the receiver for one long hold-off
    int   n_cycles = 0;
    int   n_settings = 1;

    morse_code_encoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: random backpressure, plus one long hold-off on request.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            m_axis_tready = no_idle || ($urandom_range(0, 99) >= 33);
        end
    end

    // Check every output beat against the oldest predicted segment.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_seg({m_axis_tdata[6:0], m_axis_tdata[7], m_axis_tdata[22:8],
                          m_axis_tdata[35:23], m_axis_tlast}, m_axis_tdata[39:36]);
    end

    // Mostly encodable characters, the rest any byte at all.
    function automatic logic [7:0] pick_char();
        int    roll  = $urandom_range(0, 99);
        string punct = "&'@():,=!.-?";
        if (roll < 35)
            return 8'(($urandom_range(0, 1) ? 65 : 97) + $urandom_range(0, 25));
        if (roll < 50)
            return 8'(48 + $urandom_range(0, 9));
        if (roll < 70)
            return punct.getc($urandom_range(0, 11));
        if (roll < 80)
            return CHAR_SPACE;
        return 8'($urandom_range(0, 255));
    endfunction

    // Offer one character and hold it until the block takes the beat.
    task automatic send_char(input logic [7:0] c);
        while (!no_idle && $urandom_range(0, 99) < 33) begin
            s_axis_tdata = 8'($urandom_range(0, 255));
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = c;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_char(c);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic wait_empty();
        while (sb.segs_due.size() != 0) @(negedge i_clk);
    endtask

    // Drain all predicted segments, then let a dropped character clear the block.
    task automatic settle();
        wait_empty();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Reprogram all three registers, then send random characters.
    task automatic run_phase(input logic [14:0] mode, input logic [14:0] freq,
                             input logic [14:0] dit, input int n_chars,
                             input int hold_at, input int pause_at);
        settle();
        write_reg(CFG_OUTPUT_MODE, mode);
        write_reg(CFG_TONE_FREQUENCY, freq);
        write_reg(CFG_DIT_DURATION, dit);
        n_settings++;
        for (int i = 0; i < n_chars; i++) begin
            if (i == hold_at)
                hold_req = 1'b1;
            if (i == pause_at)
                wait_empty();
            send_char(pick_char());
        end
    endtask

    initial begin
        string directed;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_OUTPUT_MODE;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: both letter cases, digit ends, every punctuation mark,
        // word space, and codes with no Morse form (control, DEL, high half).
        directed = "Az09&'@():,=!.-? [";
        for (int i = 0; i < directed.len(); i++)
            send_char(directed.getc(i));
        send_char(8'h00);
        send_char(8'h7F);
        send_char(8'h80);
        send_char(8'hFF);
        for (int i = 0; i < 20; i++)
            send_char(pick_char());

        // Text mode with both sides running flat out.
        settle();
        no_idle = 1'b1;
        write_reg(CFG_OUTPUT_MODE, 15'd1);
        n_settings++;
        for (int i = 0; i < 50; i++)
            send_char(pick_char());
        no_idle = 1'b0;

        // Top pitch and a 1000 ms dit; receiver stalls long while characters keep coming.
        run_phase(15'd0, 15'h7FFF, 15'd1000, 50, 10, -1);
        // Shortest legal dit and lowest legal pitch; sender drains midway.
        run_phase(15'd0, 15'd37, 15'd1, 50, -1, 25);
        // Out-of-range registers pass straight through: zero pitch, zero-length dits.
        run_phase(15'd0, 15'd0, 15'd0, 40, -1, -1);
        // Upper data bits must be dropped: mode from bit 0, dit from the low ten bits.
        run_phase(15'h7FFE, 15'd36, 15'h7FFF, 40, -1, -1);

        settle();
        write_reg(CFG_UNUSED, 15'h5555);
        run_phase(15'h5555, 15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)),
                  40, -1, -1);
        run_phase(15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)),
                  15'($urandom_range(0, 32767)), 30, -1, -1);

        settle();
        $display("Sent %0d characters over %0d register settings in tone and text mode;",
                 sb.n_chars, n_settings);
        $display("checked %0d segments, %0d mismatches.", sb.n_segs, sb.n_errors);
        if (sb.n_errors == 0 && sb.segs_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== morse_code_encoder.f =====
+incdir+sv
sv/mce_pkg.sv
sv/mce_lookup.sv
sv/mce_emitter.sv
sv/morse_code_encoder.sv
tb/sv/tb_top.sv
